/* rtl/sfmx_pkg.sv */
// ----------------------------------------------------------------------------
// sfmx_pkg
// Shared types, sizes and exponential tables for the softmax layer.
// ----------------------------------------------------------------------------
package sfmx_pkg;

  localparam int VecLen = 64;
  localparam int AddrW  = 6;
  localparam int CntW   = 7;

  // Fraction table: round(65536*exp(-f/256)), f = 0..255, Q1.16 (17 bit).
  typedef logic [255:0][16:0] frac_tab_t;

  // Shift-and-subtract quotient, used only while building constant tables
  function automatic logic [63:0] const_div(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build the fraction table from a truncated Q40 Taylor series.
  function automatic frac_tab_t build_frac();
    frac_tab_t   t;
    logic [63:0] term;
    logic [63:0] sum;
    for (int f = 0; f < 256; f++) begin
      term = 64'd1 << 40;
      sum  = term;
      for (int n = 1; n <= 24; n++) begin
        term = const_div(term * 64'(f), 64'd256 * 64'(n));
        sum  = sum + term;
      end
      t[f] = 17'(const_div((64'd1 << 56) + (sum >> 1), sum));
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac();

  // Integer-part table: round(65536*exp(-i)), i = 0..16.
  function automatic logic [16:0] int_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd24109;
      5'd2:    v = 17'd8869;
      5'd3:    v = 17'd3263;
      5'd4:    v = 17'd1200;
      5'd5:    v = 17'd442;
      5'd6:    v = 17'd162;
      5'd7:    v = 17'd60;
      5'd8:    v = 17'd22;
      5'd9:    v = 17'd8;
      5'd10:   v = 17'd3;
      5'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/sfmx_ram.sv */
// ----------------------------------------------------------------------------
// sfmx_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfmx_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/softmax_forward_backward_top.sv */
// ----------------------------------------------------------------------------
// softmax_forward_backward_top
// Softmax layer over one vector: forward probabilities and backward gradient.
// ----------------------------------------------------------------------------
// Words load at one per cycle until the word flagged tlast (or the 64th word).
// Then the block runs over the stored vector and emits one result word per
// element, in order, tlast on the final one; no input is taken meanwhile.
// Forward (tuser 0) first forms the exponentials element by element, then
// runs the restoring divider, which retires one quotient bit per cycle, for
// each element. Backward (tuser 1) first forms the dot product element by
// element, then the split 16x40 multiply for each element. While the receiver
// holds the output word, the sequencer waits. Element, exponential and
// probability vectors sit in three 64-entry RAMs with registered reads.
// ----------------------------------------------------------------------------
module softmax_forward_backward_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic [0:0]  in_tuser,   // [0] func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] result, [22:17] position, [23] zero
  output logic        out_tlast
);

  typedef enum logic [14:0] {
    ST_LOAD = 15'b000000000000001,
    ST_FRD  = 15'b000000000000010,
    ST_FEX  = 15'b000000000000100,
    ST_DRD  = 15'b000000000001000,
    ST_DLD  = 15'b000000000010000,
    ST_DIT  = 15'b000000000100000,
    ST_DOUT = 15'b000000001000000,
    ST_BRD  = 15'b000000010000000,
    ST_BAC  = 15'b000000100000000,
    ST_GRD  = 15'b000001000000000,
    ST_GM1  = 15'b000010000000000,
    ST_GM2  = 15'b000100000000000,
    ST_GM3  = 15'b001000000000000,
    ST_GSUM = 15'b010000000000000,
    ST_GOUT = 15'b100000000000000
  } state_t;

  localparam logic [sfmx_pkg::CntW-1:0] VecLenC = sfmx_pkg::CntW'(sfmx_pkg::VecLen);

  state_t                       state_r, state_nxt;
  logic [sfmx_pkg::CntW-1:0]    cnt_r, cnt_nxt;
  logic [sfmx_pkg::CntW-1:0]    k_r, k_nxt;
  logic                         mode_r, mode_nxt;
  logic signed [15:0]           max_r, max_nxt;
  logic signed [39:0]           acc_r, acc_nxt;
  logic [sfmx_pkg::VecLen-1:0]  pvld_r, pvld_nxt;
  logic                         ovld_r, ovld_nxt;
  logic [4:0]                   bit_r, bit_nxt;

  logic [22:0]                  rem_r, rem_nxt;
  logic [16:0]                  num_r, num_nxt;
  logic [16:0]                  q_r, q_nxt;
  logic [15:0]                  y_r, y_nxt;
  logic signed [32:0]           p1_r, p1_nxt;
  logic [35:0]                  p2_r, p2_nxt;
  logic signed [36:0]           p3_r, p3_nxt;
  logic signed [25:0]           g_r, g_nxt;
  logic [23:0]                  odata_r, odata_nxt;
  logic                         olast_r, olast_nxt;

  // RAM ports
  logic                         elem_we, exp_we, prob_we;
  logic [sfmx_pkg::AddrW-1:0]   elem_waddr;
  logic [15:0]                  elem_q, prob_q;
  logic [16:0]                  exp_wdata, exp_q, prob_wdata17;
  logic [sfmx_pkg::AddrW-1:0]   k_addr;

  // Datapath helpers
  logic                         in_acc, restart, out_free, k_end;
  logic [sfmx_pkg::CntW-1:0]    base_cnt;
  logic signed [15:0]           in_val, base_max;
  logic signed [16:0]           diff;
  logic [33:0]                  eprod;
  logic [16:0]                  e_val;
  logic [15:0]                  y_cur;
  logic signed [32:0]           ydy;
  logic [23:0]                  rem2, sum24;
  logic signed [57:0]           total;
  logic signed [15:0]           gsat;

  assign k_addr     = k_r[sfmx_pkg::AddrW-1:0];
  assign in_tready  = (state_r == ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign in_val     = $signed(in_tdata);
  assign out_free   = !ovld_r || out_tready;
  assign k_end      = ((k_r + 1'b1) == cnt_r);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // Pass change discards the partial run
  assign restart    = (cnt_r != '0) && (in_tuser[0] != mode_r);
  assign base_cnt   = restart ? '0 : cnt_r;
  assign base_max   = restart ? -16'sd32768 : max_r;
  assign elem_we    = in_acc;
  assign elem_waddr = base_cnt[sfmx_pkg::AddrW-1:0];

  // exp(x - max) from integer and fraction tables, rounded to Q1.16
  assign diff  = $signed({max_r[15], max_r}) - $signed({elem_q[15], elem_q});
  assign eprod = 34'(sfmx_pkg::int_tab(diff[12:8])) * 34'(sfmx_pkg::FRAC_TAB[diff[7:0]])
               + 34'd32768;
  assign e_val = (diff[15:8] > 8'd16) ? 17'd0 : eprod[32:16];
  assign exp_we    = (state_r == ST_FEX);
  assign exp_wdata = e_val;

  // Probability read, zero where never written
  assign y_cur = pvld_r[k_addr] ? prob_q : 16'd0;
  assign ydy   = $signed({1'b0, y_cur}) * $signed(elem_q);

  // Divider step
  assign rem2  = {rem_r, num_r[16]};
  assign sum24 = {1'b0, acc_r[22:0]};

  // Backward combine: y*dy*2^16 - y*s
  assign total = ($signed({{25{p1_r[32]}}, p1_r}) <<< 16)
               - $signed({22'd0, p2_r})
               - ($signed({{21{p3_r[36]}}, p3_r}) <<< 20);
  assign gsat  = (g_r > 26'sd32767)  ? 16'sd32767 :
                 (g_r < -26'sd32768) ? -16'sd32768 : g_r[15:0];

  assign prob_we      = (state_r == ST_DOUT) && out_free;
  assign prob_wdata17 = q_r[16] ? 17'd65535 : q_r;

  sfmx_ram #(.Width(16), .Depth(sfmx_pkg::VecLen)) u_elem (
    .clk(clk), .we(elem_we), .waddr(elem_waddr), .wdata(in_tdata),
    .raddr(k_addr), .rdata(elem_q)
  );

  sfmx_ram #(.Width(17), .Depth(sfmx_pkg::VecLen)) u_exp (
    .clk(clk), .we(exp_we), .waddr(k_addr), .wdata(exp_wdata),
    .raddr(k_addr), .rdata(exp_q)
  );

  sfmx_ram #(.Width(16), .Depth(sfmx_pkg::VecLen)) u_prob (
    .clk(clk), .we(prob_we), .waddr(k_addr), .wdata(prob_wdata17[15:0]),
    .raddr(k_addr), .rdata(prob_q)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    mode_nxt  = mode_r;
    max_nxt   = max_r;
    acc_nxt   = acc_r;
    pvld_nxt  = pvld_r;
    ovld_nxt  = ovld_r;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    q_nxt     = q_r;
    y_nxt     = y_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    p3_nxt    = p3_r;
    g_nxt     = g_r;
    odata_nxt = odata_r;
    olast_nxt = olast_r;

    // Drop the output word once taken
    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          mode_nxt = in_tuser[0];
          cnt_nxt  = base_cnt + 1'b1;
          max_nxt  = (!in_tuser[0] && (in_val > base_max)) ? in_val : base_max;
          k_nxt    = '0;
          if (in_tlast || (cnt_nxt == VecLenC)) begin
            state_nxt = in_tuser[0] ? ST_BRD : ST_FRD;
          end
        end
      end
      ST_FRD: state_nxt = ST_FEX;
      ST_FEX: begin
        acc_nxt = acc_r + 40'(e_val);
        if (k_end) begin
          k_nxt     = '0;
          state_nxt = ST_DRD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_FRD;
        end
      end
      ST_DRD: state_nxt = ST_DLD;
      ST_DLD: begin
        rem_nxt   = {7'd0, exp_q[16:1]};
        num_nxt   = {exp_q[0], 16'd0};
        q_nxt     = '0;
        bit_nxt   = '0;
        state_nxt = ST_DIT;
      end
      ST_DIT: begin
        if (rem2 >= sum24) begin
          rem_nxt = 23'(rem2 - sum24);
          q_nxt   = {q_r[15:0], 1'b1};
        end else begin
          rem_nxt = rem2[22:0];
          q_nxt   = {q_r[15:0], 1'b0};
        end
        num_nxt = {num_r[15:0], 1'b0};
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 5'd16) begin
          state_nxt = ST_DOUT;
        end
      end
      ST_DOUT: begin
        if (out_free) begin
          ovld_nxt         = 1'b1;
          odata_nxt        = {1'b0, k_addr, prob_wdata17};
          olast_nxt        = k_end;
          pvld_nxt[k_addr] = 1'b1;
          if (k_end) begin
            cnt_nxt   = '0;
            max_nxt   = -16'sd32768;
            acc_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_DRD;
          end
        end
      end
      ST_BRD: state_nxt = ST_BAC;
      ST_BAC: begin
        acc_nxt = acc_r + 40'(ydy);
        if (k_end) begin
          k_nxt     = '0;
          state_nxt = ST_GRD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_BRD;
        end
      end
      ST_GRD: state_nxt = ST_GM1;
      ST_GM1: begin
        y_nxt     = y_cur;
        p1_nxt    = ydy;
        state_nxt = ST_GM2;
      end
      ST_GM2: begin
        p2_nxt    = 36'(y_r) * 36'(acc_r[19:0]);
        state_nxt = ST_GM3;
      end
      ST_GM3: begin
        p3_nxt    = $signed({1'b0, y_r}) * $signed(acc_r[39:20]);
        state_nxt = ST_GSUM;
      end
      ST_GSUM: begin
        g_nxt     = total[57:32];
        state_nxt = ST_GOUT;
      end
      ST_GOUT: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          odata_nxt = {1'b0, k_addr, gsat[15], gsat};
          olast_nxt = k_end;
          if (k_end) begin
            cnt_nxt   = '0;
            max_nxt   = -16'sd32768;
            acc_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_GRD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      k_r     <= '0;
      mode_r  <= 1'b0;
      max_r   <= -16'sd32768;
      acc_r   <= '0;
      pvld_r  <= '0;
      ovld_r  <= 1'b0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      mode_r  <= mode_nxt;
      max_r   <= max_nxt;
      acc_r   <= acc_nxt;
      pvld_r  <= pvld_nxt;
      ovld_r  <= ovld_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
    q_r     <= q_nxt;
    y_r     <= y_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    p3_r    <= p3_nxt;
    g_r     <= g_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

endmodule

/* sim/tb_softmax_forward_backward_top.sv */
// ----------------------------------------------------------------------------
// tb_softmax_forward_backward_top
// Self-checking bench for the softmax layer: forward and backward passes.
// ----------------------------------------------------------------------------
// A directed table covers reset behavior, field extremes, pass changes in the
// middle of a vector and backward runs longer than the last forward run; the
// 64-word cap is hit next. Random vectors follow, mostly well formed, some broken.
// Every result word is checked against a bit-level predictor of the layer.
// ----------------------------------------------------------------------------
module tb_softmax_forward_backward_top;

  typedef enum logic {
    FUNC_FWD = 1'b0,
    FUNC_BWD = 1'b1
  } func_e;

  typedef struct packed {
    logic [16:0] result;
    logic [5:0]  position;
    logic        final_res;
  } res_t;

  typedef struct {
    func_e       func;
    logic [15:0] value;
    logic        last;
    logic        chk;       // typed-in expectation for the first result
    logic [16:0] exp_first;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  always #4 clk = ~clk;

  softmax_forward_backward_top dut (.*);

  // Predictor state
  logic [16:0] frac_lut [256];
  logic [16:0] int_lut [17];
  logic signed [15:0] elem_q [64];
  logic [16:0] expo_q [64];
  logic [15:0] prob_cache [64];
  int unsigned elem_cnt;
  logic signed [15:0] run_max;
  func_e       run_func;

  res_t        pending_res [$];
  logic [16:0] typed_first [$];
  int          n_err = 0;
  int          n_res = 0;
  int          n_fwd = 0;
  int          n_bwd = 0;
  bit          hold_off = 1'b0;

  function automatic void build_luts();
    logic [63:0] term, sum;
    int it [17] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22,
                    8, 3, 1, 0, 0, 0, 0, 0};
    for (int f = 0; f < 256; f++) begin
      term = 64'd1 << 40;
      sum  = term;
      for (int n = 1; n <= 24; n++) begin
        term = term * 64'(f) / (64'd256 * 64'(n));
        sum += term;
      end
      frac_lut[f] = 17'(((64'd1 << 56) + sum / 2) / sum);
    end
    for (int i = 0; i < 17; i++) int_lut[i] = 17'(it[i]);
  endfunction

  function automatic logic [16:0] exp_of_gap(int unsigned d);
    int unsigned i = d >> 8;
    longint unsigned p;
    if (i > 16) return 17'd0;
    p = longint'(int_lut[i]) * longint'(frac_lut[d & 255]) + 32768;
    return 17'(p >> 16);
  endfunction

  function automatic void clear_vec();
    elem_cnt = 0;
    run_max  = -16'sd32768;
  endfunction

  // Advance the predictor by one accepted word; queue any results
  function automatic void predict_word(func_e f, logic [15:0] v, logic lst);
    int unsigned n;
    longint acc, diff, r, prod;
    longint unsigned pq;
    if (elem_cnt > 0 && f != run_func) clear_vec();
    run_func = f;
    elem_q[elem_cnt & 63] = v;
    elem_cnt++;
    if (f == FUNC_FWD && $signed(v) > run_max) run_max = v;
    if (!lst && elem_cnt < 64) return;
    n = elem_cnt;
    acc = 0;
    if (f == FUNC_FWD) begin
      n_fwd++;
      for (int k = 0; k < n; k++) begin
        expo_q[k] = exp_of_gap(int'(run_max) - int'(elem_q[k]));
        acc += expo_q[k];
      end
      for (int k = 0; k < n; k++) begin
        pq = (longint'(expo_q[k]) << 16) / acc;
        if (pq > 65535) pq = 65535;
        prob_cache[k] = 16'(pq);
        pending_res.push_back('{17'(pq), 6'(k), k + 1 == n});
      end
    end else begin
      n_bwd++;
      for (int k = 0; k < n; k++) acc += longint'(prob_cache[k]) * longint'(elem_q[k]);
      for (int k = 0; k < n; k++) begin
        diff = longint'(elem_q[k]) * 65536 - acc;
        prod = longint'(prob_cache[k]) * diff;
        r = prod >>> 32;  // arithmetic shift floors
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        pending_res.push_back('{17'(r), 6'(k), k + 1 == n});
      end
    end
    clear_vec();
  endfunction

  // Send one word, holding valid until it is taken
  task automatic send_word(func_e f, logic [15:0] v, logic lst);
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= v;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    predict_word(f, v, lst);
  endtask

  task automatic idle_in(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall pattern, plus a long hold-off on request
  initial begin
    int ph = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      ph++;
      if (hold_off) out_tready <= 1'b0;
      else if ((ph / 200) % 3 == 0) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[16:0], out_tdata[22:17], out_tlast};
      n_res++;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_tdata);
        n_err++;
      end else begin
        want = pending_res.pop_front();
        if (got !== want || out_tdata[23] !== 1'b0) begin
          $display("%0t: mismatch exp res=%h pos=%0d last=%b act res=%h pos=%0d last=%b",
                   $time, want.result, want.position, want.final_res,
                   got.result, got.position, got.final_res);
          n_err++;
        end
        if (want.position == 0 && typed_first.size() != 0) begin
          if (got.result !== typed_first[0]) begin
            $display("%0t: mismatch exp first=%h act=%h", $time, typed_first[0],
                     got.result);
            n_err++;
          end
          void'(typed_first.pop_front());
        end
      end
    end
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t tbl [$];
    int len;
    func_e f;
    build_luts();
    for (int k = 0; k < 64; k++) prob_cache[k] = '0;
    run_func = FUNC_FWD;
    clear_vec();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: backward before forward gives zero; single forward is 65535
    tbl.push_back('{FUNC_BWD, 16'h7fff, 1'b1, 1'b1, 17'd0});
    tbl.push_back('{FUNC_FWD, 16'h8000, 1'b1, 1'b1, 17'd65535});
    tbl.push_back('{FUNC_FWD, 16'h7fff, 1'b1, 1'b1, 17'd65535});
    // Extremes in one vector: far element underflows
    tbl.push_back('{FUNC_FWD, 16'h7fff, 1'b0, 1'b1, 17'd65535});
    tbl.push_back('{FUNC_FWD, 16'h8000, 1'b1, 1'b0, 17'd0});
    tbl.push_back('{FUNC_FWD, 16'h0000, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_FWD, 16'h0100, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_FWD, 16'hff00, 1'b1, 1'b0, 17'd0});
    // Backward over three cached, then longer than forward
    tbl.push_back('{FUNC_BWD, 16'h7fff, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'h8000, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'h0100, 1'b1, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'h8000, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'h7fff, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'h5555, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'haaaa, 1'b1, 1'b0, 17'd0});
    // Pass change mid-vector drops the partial run
    tbl.push_back('{FUNC_FWD, 16'h1234, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'h0200, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_FWD, 16'h0080, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_FWD, 16'h0000, 1'b1, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'h0100, 1'b0, 1'b0, 17'd0});
    tbl.push_back('{FUNC_BWD, 16'hff00, 1'b1, 1'b0, 17'd0});
    foreach (tbl[i]) begin
      if (tbl[i].chk) typed_first.push_back(tbl[i].exp_first);
      send_word(tbl[i].func, tbl[i].value, tbl[i].last);
      if ($urandom_range(0, 2) == 0) idle_in($urandom_range(1, 3));
    end
    drain_all();

    // Vector too long: 64 words with no last flag, both passes
    for (int k = 0; k < 64; k++) send_word(FUNC_FWD, 16'($urandom), 1'b0);
    for (int k = 0; k < 64; k++) send_word(FUNC_BWD, 16'($urandom), 1'b0);

    // Long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_word(FUNC_FWD, 16'($urandom), k % 4 == 3);
    join
    drain_all();

    // Random: bursts of well-formed vectors, some noise
    for (int v = 0; v < 44; v++) begin
      f = func_e'($urandom_range(0, 1));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        logic [15:0] val;
        case ($urandom_range(0, 3))
          0: val = 16'($urandom);
          1: val = 16'($signed(16'($urandom_range(0, 2047))) - 1024);
          2: val = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          default: val = 16'($signed(16'($urandom_range(0, 511))) - 256);
        endcase
        // Occasional broken vector: flip the pass partway
        if (k > 0 && $urandom_range(0, 19) == 0) f = func_e'(~f);
        send_word(f, val, k == len - 1);
        if ($urandom_range(0, 4) == 0) idle_in($urandom_range(1, 6));
      end
      if ($urandom_range(0, 7) == 0) drain_all();
    end
    drain_all();
    repeat (50) @(posedge clk);

    $display("covered %0d forward and %0d backward runs, %0d result words",
             n_fwd, n_bwd, n_res);
    if (n_err == 0 && pending_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
